/* src/identifier_intern_table_macros.svh */
// Assertion macros for the identifier intern table.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef IDENTIFIER_INTERN_TABLE_MACROS_SVH
`define IDENTIFIER_INTERN_TABLE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ITT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define ITT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/iit_pkg.sv */
// Shared types, constants and helper functions of the identifier intern table.
// No dependencies; imported by every module of the block.
package iit_pkg;

    localparam int CHAR_BUDGET_DEF = 321;
    localparam int MAX_ENTRIES_DEF = 160;
    localparam int TOKEN_MAX_CHARS = 5;
    localparam int TEXT_W          = 40;
    localparam int LEN_W           = 4;
    localparam int SIZE_W          = 3;
    localparam int OUT_IDX_W       = 8;
    localparam int STATUS_W        = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [SIZE_W-1:0] size;
    } t_query;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_link;

    // Keeps the first len bytes of the token and zeroes the rest.
    function automatic logic [TEXT_W-1:0] mask_text(input logic [TEXT_W-1:0] text,
                                                     input logic [LEN_W-1:0] len);
        logic [TEXT_W-1:0] masked;
        masked = '0;
        for (int b = 0; b < TOKEN_MAX_CHARS; b++) begin
            if (len > LEN_W'(b)) begin
                masked[b*8 +: 8] = text[b*8 +: 8];
            end
        end
        return masked;
    endfunction

endpackage

/* src/iit_cell.sv */
// One cell of the lookup chain: holds one stored identifier and compares it
// with the query as the search item passes. Depends on iit_pkg.
module iit_cell #(
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iit_pkg::t_query      i_query,
    input  logic [CNT_W-1:0]     i_count,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  iit_pkg::t_link       i_link,
    input  logic [IDX_W-1:0]     i_link_idx,
    output iit_pkg::t_link       o_link,
    output logic [IDX_W-1:0]     o_link_idx
);
    import iit_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [TEXT_W-1:0] r_text;
    logic [SIZE_W-1:0] r_size;
    t_link             r_link;
    t_link             n_link;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              w_match;

    // Only entries below the fill count hold a stored identifier.
    assign w_match = (i_count > CNT_W'(CELL_IDX)) && (r_size == i_query.size)
                     && (r_text == i_query.text);

    always_comb begin
        n_link.valid = i_link.valid;
        n_link.hit   = i_link.hit || w_match;
        n_idx        = i_link.hit ? i_link_idx : MY_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_text <= i_query.text;
            r_size <= i_query.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    assign o_link     = r_link;
    assign o_link_idx = r_idx;

endmodule

/* src/identifier_intern_table.sv */
// Identifier intern table: a row of MAX_ENTRIES cells searched by an item that moves one
// cell per cycle, with a controller that decides and appends. Depends on iit_pkg, iit_cell.
// An accepted item is registered, passes along the cell chain, is captured at its tail, then decided.
// One item in flight: the next is taken only once the last result is loaded into the output register.
// Reset clears the fill count to zero and the character count to one; no clearing pass.
module identifier_intern_table #(
    parameter int CHAR_BUDGET = iit_pkg::CHAR_BUDGET_DEF,
    parameter int MAX_ENTRIES = iit_pkg::MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // token_chars[39:0], token_length[43:40], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[1:0], entry_index[9:2], zeros
);
    import iit_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int USED_W = $clog2(CHAR_BUDGET + 1);
    localparam int SUM_W  = USED_W + 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_launch;
    logic [TEXT_W-1:0]   r_text;
    logic [LEN_W-1:0]    r_len;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hidx;
    logic [CNT_W-1:0]    r_count;
    logic [USED_W-1:0]   r_used;
    logic                r_wr_en;
    logic [IDX_W-1:0]    r_wr_idx;
    logic                r_m_valid;
    t_status             r_m_status;
    logic [OUT_IDX_W-1:0] r_m_index;

    t_query              w_query;
    t_link               w_link [MAX_ENTRIES+1];
    logic [IDX_W-1:0]    w_idx  [MAX_ENTRIES+1];
    logic                w_accept;
    logic                w_out_free;
    logic                w_load;
    logic                w_too_long;
    logic                w_full;
    logic                w_insert;
    logic [SUM_W-1:0]    w_sum;
    t_status             w_status;
    logic [OUT_IDX_W-1:0] w_index;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_load        = (r_state == S_DECIDE) && w_out_free;

    assign w_query.text = r_text;
    assign w_query.size = r_len[SIZE_W-1:0];

    assign w_link[0].valid = r_launch;
    assign w_link[0].hit   = 1'b0;
    assign w_idx[0]        = '0;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        iit_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_query    (w_query),
            .i_count    (r_count),
            .i_wr_en    (r_wr_en),
            .i_wr_idx   (r_wr_idx),
            .i_link     (w_link[k]),
            .i_link_idx (w_idx[k]),
            .o_link     (w_link[k+1]),
            .o_link_idx (w_idx[k+1])
        );
    end

    assign w_too_long = r_len > LEN_W'(TOKEN_MAX_CHARS);
    assign w_sum      = SUM_W'(r_used) + SUM_W'(r_len) + SUM_W'(1);
    assign w_full     = (r_count == CNT_W'(MAX_ENTRIES)) || (w_sum > SUM_W'(CHAR_BUDGET));
    assign w_insert   = !w_too_long && !r_hit && !w_full;

    always_comb begin
        if (w_too_long) begin
            w_status = ST_TOO_LONG;
            w_index  = '0;
        end else if (r_hit) begin
            w_status = ST_FOUND;
            w_index  = OUT_IDX_W'(r_hidx);
        end else if (w_full) begin
            w_status = ST_FULL;
            w_index  = '0;
        end else begin
            w_status = ST_INSERTED;
            w_index  = OUT_IDX_W'(r_count);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_link[MAX_ENTRIES].valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_count   <= '0;
            r_used    <= USED_W'(1);
            r_wr_en   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept;
            r_wr_en  <= w_load && w_insert;
            if (w_load && w_insert) begin
                r_count <= r_count + CNT_W'(1);
                r_used  <= w_sum[USED_W-1:0];
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_text <= mask_text(s_axis_tdata[TEXT_W-1:0], s_axis_tdata[TEXT_W+LEN_W-1:TEXT_W]);
            r_len  <= s_axis_tdata[TEXT_W+LEN_W-1:TEXT_W];
        end
        if ((r_state == S_SEARCH) && w_link[MAX_ENTRIES].valid) begin
            r_hit  <= w_link[MAX_ENTRIES].hit;
            r_hidx <= w_idx[MAX_ENTRIES];
        end
        if (w_load) begin
            r_wr_idx   <= r_count[IDX_W-1:0];
            r_m_status <= w_status;
            r_m_index  <= w_index;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_index, r_m_status};

`include "identifier_intern_table_macros.svh"

    `ITT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ENTRIES), "Fill count exceeds store depth.")
    `ITT_ASSERT_IMP(a_used_bound, 1'b1, r_used <= USED_W'(CHAR_BUDGET), "Character count exceeds budget.")
    `ITT_ASSERT_IMP(a_tail_search, w_link[MAX_ENTRIES].valid, r_state == S_SEARCH, "Search item left the chain outside a search.")
    `ITT_ASSERT_IMP(a_write_count, r_wr_en, r_count == CNT_W'(r_wr_idx) + CNT_W'(1), "Append index does not match the fill count.")
    `ITT_ASSERT_NXT(a_result_load, w_load, r_m_valid, "Decided item was not presented.")

endmodule

/* sim/identifier_intern_table_tb.sv */
// Self-checking testbench for identifier_intern_table: stream items in, status and index out.
// Holds its own model of the token store and compares every result. Needs iit_pkg and the RTL.
`timescale 1ns / 100ps

module identifier_intern_table_tb;
    import iit_pkg::*;

    localparam int RANDOM_ITEMS   = 1130;
    localparam int CALM_ITEMS     = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 600;

    typedef struct {
        logic [TEXT_W-1:0] chars;
        logic [LEN_W-1:0]  len;
        bit                drain_first;
        bit                quiet;
    } t_token_item;

    typedef struct {
        t_status              status;
        logic [OUT_IDX_W-1:0] index;
    } t_intern_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // token_chars[39:0], token_length[43:40], zeros
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // status[1:0], entry_index[9:2], zeros

    t_token_item    token_queue[$];
    t_token_item    token_pool[$];
    t_intern_result expected_lookups[$];

    logic [TEXT_W-1:0] stored_text[MAX_ENTRIES_DEF];
    logic [LEN_W-1:0]  stored_len[MAX_ENTRIES_DEF];
    int stored_count = 0;
    int chars_spent = 1;
    int status_tally[4] = '{0, 0, 0, 0};

    int  send_gap = 0;
    int  sink_stall = 0;
    int  long_hold = 0;
    bit  long_hold_done = 1'b0;
    bit  quiet_phase = 1'b0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;

    identifier_intern_table #(
        .CHAR_BUDGET(CHAR_BUDGET_DEF),
        .MAX_ENTRIES(MAX_ENTRIES_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Mask of the bytes that belong to a token of the given length (five at most).
    function automatic logic [TEXT_W-1:0] byte_keep(input logic [LEN_W-1:0] len);
        logic [63:0] ones;
        ones = (64'd1 << (8 * len)) - 64'd1;
        return ones[TEXT_W-1:0];
    endfunction

    function automatic logic [TEXT_W-1:0] random_chars();
        return {8'($urandom_range(0, 255)), 32'($urandom())};
    endfunction

    task automatic add_token(input logic [TEXT_W-1:0] chars, input logic [LEN_W-1:0] len,
                             input bit drain_first, input bit quiet);
        t_token_item item;
        item.chars       = chars;
        item.len         = len;
        item.drain_first = drain_first;
        item.quiet       = quiet;
        token_queue.push_back(item);
        if (len <= TOKEN_MAX_CHARS) begin
            token_pool.push_back(item);
        end
    endtask

    // Length check first, then the lookup, then the room check, then the append.
    task automatic intern_predict(input logic [TEXT_W-1:0] chars, input logic [LEN_W-1:0] len);
        t_intern_result r;
        logic [TEXT_W-1:0] key;
        int hit;
        r.status = ST_TOO_LONG;
        r.index  = '0;
        hit      = -1;
        if (len <= TOKEN_MAX_CHARS) begin
            key = chars & byte_keep(len);
            for (int e = 0; e < stored_count; e++) begin
                if (hit < 0 && stored_len[e] == len && stored_text[e] == key) begin
                    hit = e;
                end
            end
            if (hit >= 0) begin
                r.status = ST_FOUND;
                r.index  = OUT_IDX_W'(hit);
            end else if (stored_count >= MAX_ENTRIES_DEF ||
                         chars_spent + len + 1 > CHAR_BUDGET_DEF) begin
                r.status = ST_FULL;
            end else begin
                stored_text[stored_count] = key;
                stored_len[stored_count]  = len;
                r.status     = ST_INSERTED;
                r.index      = OUT_IDX_W'(stored_count);
                stored_count = stored_count + 1;
                chars_spent  = chars_spent + len + 1;
            end
        end
        status_tally[r.status]++;
        expected_lookups.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_token_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                intern_predict(s_axis_tdata[TEXT_W-1:0], s_axis_tdata[TEXT_W+LEN_W-1:TEXT_W]);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (token_queue.size() > 0 &&
                             !(token_queue[0].drain_first && expected_lookups.size() > 0)) begin
                    nxt = token_queue.pop_front();
                    quiet_phase = nxt.quiet;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, nxt.len, nxt.chars};
                    if (!nxt.quiet && $urandom_range(0, 4) == 0) begin
                        send_gap = $urandom_range(1, 4);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold--;
            m_axis_tready <= 1'b0;
        end else if (results_checked == 40 && !long_hold_done) begin
            long_hold_done = 1'b1;
            long_hold = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_intern_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_lookups.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected item: status %0d index %0d",
                             m_axis_tdata[1:0], m_axis_tdata[9:2]);
                end
                mismatches++;
            end else begin
                want = expected_lookups.pop_front();
                if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[9:2] !== want.index) begin
                    if (mismatches < 10) begin
                        $display("item %0d: expected status %0d index %0d, got status %0d index %0d",
                                 results_checked, want.status, want.index,
                                 m_axis_tdata[1:0], m_axis_tdata[9:2]);
                    end
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[identifier_intern_table] ERROR");
            $finish;
        end
    end

    initial begin
        t_token_item src;
        logic [TEXT_W-1:0] chars;
        logic [TEXT_W-1:0] keep;
        logic [LEN_W-1:0] len;
        int pick;

        // The empty token, stored once and found again whatever the unused bytes hold.
        add_token(random_chars(), 4'd0, 1'b0, 1'b0);
        add_token(40'hFF_FFFF_FFFF, 4'd0, 1'b0, 1'b0);
        add_token(40'hFF_FFFF_FFFF, 4'd5, 1'b0, 1'b0);
        add_token(40'h00_0000_0000, 4'd5, 1'b0, 1'b0);
        add_token(40'hAB_CDEF_0000, 4'd1, 1'b0, 1'b0);
        add_token(40'h00_0000_0000, 4'd2, 1'b0, 1'b0);
        add_token(40'hFF_FFFF_FFFF, 4'd5, 1'b0, 1'b0);
        add_token(40'hFF_FFFF_FFFF, 4'd4, 1'b0, 1'b0);
        add_token(40'h12_3400_0000, 4'd4, 1'b0, 1'b0);
        add_token(40'h55_AA63_6261, 4'd3, 1'b0, 1'b0);
        add_token(40'hAA_5563_6261, 4'd3, 1'b0, 1'b0);
        add_token(40'hFF_FFFF_FFFF, 4'd6, 1'b0, 1'b0);
        add_token(40'hFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0);
        add_token(random_chars(), 4'd8, 1'b0, 1'b0);
        add_token(40'h00_0000_00FF, 4'd1, 1'b0, 1'b0);
        add_token(40'h00_0000_0000, 4'd1, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || token_pool.size() == 0) begin
                len   = ($urandom_range(0, 9) < 7) ? 4'd1 : LEN_W'($urandom_range(0, 5));
                chars = random_chars();
            end else if (pick < 82) begin
                src   = token_pool[$urandom_range(0, token_pool.size() - 1)];
                len   = src.len;
                keep  = byte_keep(len);
                chars = (src.chars & keep) | (random_chars() & ~keep);
            end else begin
                len   = LEN_W'($urandom_range(6, 15));
                chars = random_chars();
            end
            add_token(chars, len, n == 500, n >= RANDOM_ITEMS - CALM_ITEMS);
        end

        @(posedge i_rst_n);
        while (token_queue.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_lookups.size() > 0) @(posedge i_clk);
        repeat (MAX_ENTRIES_DEF + 40) @(posedge i_clk);

        $display("%0d items checked: %0d found, %0d inserted, %0d too long, %0d full",
                 results_checked, status_tally[ST_FOUND], status_tally[ST_INSERTED],
                 status_tally[ST_TOO_LONG], status_tally[ST_FULL]);
        $display("store ends with %0d tokens and %0d of %0d characters used, %0d mismatches",
                 stored_count, chars_spent, CHAR_BUDGET_DEF, mismatches);
        if (mismatches == 0) begin
            $display("[identifier_intern_table] OK");
        end else begin
            $display("[identifier_intern_table] ERROR");
        end
        $finish;
    end

endmodule

/* identifier_intern_table.f */
+incdir+src
src/iit_pkg.sv
src/iit_cell.sv
src/identifier_intern_table.sv
sim/identifier_intern_table_tb.sv
